[hdl/huffman_codec_unit_macros.svh]
// Assertion macros for the Huffman codec unit.
// Used by huffman_codec_unit.sv; expects clk_i and rst_ni in scope.
`ifndef HUFFMAN_CODEC_UNIT_MACROS_SVH
`define HUFFMAN_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define HCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define HCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/huff_pkg.sv]
// Shared constants, codes and types for the Huffman codec unit.
// No dependencies.
`default_nettype none

package huff_pkg;

  localparam int LEAVES = 27;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int ROOT   = 2 * LEAVES - 2;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LEAF_W = 5;
  localparam int WGT_W  = 24;
  localparam int LOAD_W = 16;
  localparam int CODE_W = 26;
  localparam int LEN_W  = 5;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd2;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] RK_BUILD  = 2'd0;
  localparam logic [KIND_W-1:0] RK_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] RK_DECODE = 2'd2;

  // control into the two-minimum tracker
  typedef struct packed {
    logic             clear;
    logic             sample;
    logic [WGT_W-1:0] weight;
    logic [IDX_W-1:0] index;
  } min_ctrl_t;

  // running result of the tracker
  typedef struct packed {
    logic [IDX_W-1:0] p1;
    logic [IDX_W-1:0] p2;
    logic [WGT_W-1:0] least1;
    logic [WGT_W-1:0] least2;
    logic             have2;
  } min_stat_t;

endpackage

`default_nettype wire

[hdl/huff_if.sv]
// Valid/ready channel interfaces for the codec input and result streams.
// Depends on huff_pkg.
`default_nettype none

interface huff_in_if;
  logic                        valid;
  logic                        ready;
  logic [huff_pkg::OP_W-1:0]   opcode;
  logic [huff_pkg::LEAF_W-1:0] symbol;
  logic [huff_pkg::LOAD_W-1:0] weight;
  logic                        code_bit;

  modport source (output valid, opcode, symbol, weight, code_bit, input ready);
  modport sink   (input valid, opcode, symbol, weight, code_bit, output ready);
endinterface

interface huff_out_if;
  logic                        valid;
  logic                        ready;
  logic [huff_pkg::KIND_W-1:0] result_kind;
  logic [huff_pkg::LEAF_W-1:0] out_symbol;
  logic [huff_pkg::CODE_W-1:0] code_word;
  logic [huff_pkg::LEN_W-1:0]  code_length;

  modport source (output valid, result_kind, out_symbol, code_word, code_length, input ready);
  modport sink   (input valid, result_kind, out_symbol, code_word, code_length, output ready);
endinterface

`default_nettype wire

[hdl/huff_min_track.sv]
// Shared compare unit: tracks the two lightest parentless nodes of a scan.
// Depends on huff_pkg.
`default_nettype none

module huff_min_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  huff_pkg::min_ctrl_t ctrl_i,
  output huff_pkg::min_stat_t stat_o
);
  import huff_pkg::*;

  logic             have1_q, have2_q;
  logic [WGT_W-1:0] least1_q, least2_q;
  logic [IDX_W-1:0] p1_q, p2_q;
  logic             lt1, lt2;

  // strict less-than keeps the earlier index on a tie
  assign lt1 = !have1_q || (ctrl_i.weight < least1_q);
  assign lt2 = !have2_q || (ctrl_i.weight < least2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have1_q  <= 1'b0;
      have2_q  <= 1'b0;
      least1_q <= '0;
      least2_q <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else if (ctrl_i.clear) begin
      have1_q <= 1'b0;
      have2_q <= 1'b0;
    end else if (ctrl_i.sample) begin
      if (lt1) begin
        least2_q <= least1_q;
        p2_q     <= p1_q;
        have2_q  <= have1_q;
        least1_q <= ctrl_i.weight;
        p1_q     <= ctrl_i.index;
        have1_q  <= 1'b1;
      end else if (lt2) begin
        least2_q <= ctrl_i.weight;
        p2_q     <= ctrl_i.index;
        have2_q  <= 1'b1;
      end
    end
  end

  assign stat_o.p1     = p1_q;
  assign stat_o.p2     = p2_q;
  assign stat_o.least1 = least1_q;
  assign stat_o.least2 = least2_q;
  assign stat_o.have2  = have2_q;

endmodule

`default_nettype wire

[hdl/huffman_codec_unit.sv]
// The result is registered on the output.
// Build: for each merge node i=27..52, a scan of all lower nodes through the compare
// unit and two merge states, then per leaf a code walk up the parent memory.
// One transaction at a time; a new one is taken when idle and the result has gone.
// Reset (async, active low) clears control, leaf valid flags and tree flags at once;
// no clearing pass is needed.
`default_nettype none
`include "huffman_codec_unit_macros.svh"

module huffman_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  huff_in_if.sink     in_i,
  huff_out_if.source  out_o
);
  import huff_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WAIT, ST_SCAN, ST_MERGE1, ST_MERGE2,
    ST_CODE_START, ST_CODE_CHK, ST_CODE_STEP, ST_ENC, ST_DEC
  } state_e;

  state_e state_q;

  // node memories
  logic [WGT_W-1:0]       wgt_mem [NODES];
  logic [IDX_W-1:0]       par_mem [NODES];
  logic [IDX_W-1:0]       left_mem [NODES];
  logic [IDX_W-1:0]       right_mem [NODES];
  logic [LEN_W+CODE_W-1:0] code_mem [LEAVES];

  logic [WGT_W-1:0]        wgt_rd_q;
  logic [IDX_W-1:0]        par_rd_q, left_rd_q, right_rd_q;
  logic [LEN_W+CODE_W-1:0] code_rd_q;

  // control registers
  logic [LEAVES-1:0] leaf_valid_q;
  logic [NODES-1:0]  has_parent_q;
  logic              built_q;
  logic [IDX_W-1:0]  decode_node_q;
  logic [IDX_W-1:0]  i_q, j_q, rd_idx_q, c_q, p_q;
  logic              rd_vld_q;
  logic [LEAF_W-1:0] leaf_q, sym_q;
  logic              bit_q;
  logic [CODE_W-1:0] word_q;
  logic [LEN_W-1:0]  len_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [LEAF_W-1:0] osym_q;
  logic [CODE_W-1:0] oword_q;
  logic [LEN_W-1:0]  olen_q;

  min_ctrl_t mctrl;
  min_stat_t mstat;

  logic              accept, out_take;
  logic [IDX_W-1:0]  par_raddr, lr_raddr;
  logic [LEAF_W-1:0] code_raddr;
  logic [IDX_W-1:0]  dec_next;
  logic              walk_end;
  logic              step_bit;

  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign out_take   = out_valid_q && out_o.ready;

  // shared compare unit
  huff_min_track u_min (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctrl),
    .stat_o (mstat)
  );

  always_comb begin
    mctrl.clear  = (state_q == ST_IDLE) || (state_q == ST_MERGE2);
    mctrl.sample = (state_q == ST_SCAN) && rd_vld_q && !has_parent_q[rd_idx_q];
    mctrl.index  = rd_idx_q;
    if ((rd_idx_q < IDX_W'(LEAVES)) && !leaf_valid_q[rd_idx_q[LEAF_W-1:0]]) begin
      mctrl.weight = '0;
    end else begin
      mctrl.weight = wgt_rd_q;
    end
  end

  // read address selection
  always_comb begin
    case (state_q)
      ST_CODE_START: par_raddr = IDX_W'(leaf_q);
      ST_CODE_CHK:   par_raddr = par_rd_q;
      ST_CODE_STEP:  par_raddr = p_q;
      default:       par_raddr = '0;
    endcase
    lr_raddr   = (state_q == ST_CODE_CHK) ? par_rd_q : decode_node_q;
    code_raddr = (in_i.symbol < LEAF_W'(LEAVES)) ? in_i.symbol : '0;
  end

  assign walk_end = !has_parent_q[c_q] || (len_q == LEN_W'(LEAVES - 1));
  assign step_bit = (left_rd_q != c_q);
  assign dec_next = !built_q ? '0 : (bit_q ? right_rd_q : left_rd_q);

  // memories: one write, one registered read each
  always_ff @(posedge clk_i) begin
    wgt_rd_q   <= wgt_mem[j_q];
    par_rd_q   <= par_mem[par_raddr];
    left_rd_q  <= left_mem[lr_raddr];
    right_rd_q <= right_mem[lr_raddr];
    code_rd_q  <= code_mem[code_raddr];
    if (accept && (in_i.opcode == OP_LOAD) && (in_i.symbol < LEAF_W'(LEAVES))) begin
      wgt_mem[IDX_W'(in_i.symbol)] <= WGT_W'(in_i.weight);
    end else if (state_q == ST_MERGE1) begin
      wgt_mem[i_q] <= mstat.least1 + mstat.least2;
    end
    if (state_q == ST_MERGE1) begin
      par_mem[mstat.p1] <= i_q;
      left_mem[i_q]     <= mstat.p1;
      right_mem[i_q]    <= mstat.p2;
    end else if (state_q == ST_MERGE2) begin
      par_mem[mstat.p2] <= i_q;
    end
    if ((state_q == ST_CODE_CHK) && walk_end) begin
      code_mem[leaf_q] <= {len_q, word_q};
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      leaf_valid_q  <= '0;
      has_parent_q  <= '0;
      built_q       <= 1'b0;
      decode_node_q <= IDX_W'(ROOT);
      i_q           <= '0;
      j_q           <= '0;
      rd_idx_q      <= '0;
      rd_vld_q      <= 1'b0;
      c_q           <= '0;
      p_q           <= '0;
      leaf_q        <= '0;
      sym_q         <= '0;
      bit_q         <= 1'b0;
      word_q        <= '0;
      len_q         <= '0;
      out_valid_q   <= 1'b0;
      kind_q        <= RK_BUILD;
      osym_q        <= '0;
      oword_q       <= '0;
      olen_q        <= '0;
    end else begin
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sym_q <= in_i.symbol;
            bit_q <= in_i.code_bit;
            case (in_i.opcode)
              OP_LOAD: begin
                if (in_i.symbol < LEAF_W'(LEAVES)) begin
                  leaf_valid_q[in_i.symbol] <= 1'b1;
                end
                state_q <= ST_WAIT;
              end
              OP_BUILD: begin
                has_parent_q <= '0;
                i_q          <= IDX_W'(LEAVES);
                j_q          <= '0;
                rd_vld_q     <= 1'b0;
                state_q      <= ST_SCAN;
              end
              OP_ENCODE: state_q <= ST_ENC;
              default:   state_q <= ST_DEC;
            endcase
          end
        end
        ST_WAIT: state_q <= ST_IDLE;
        // one node per cycle through the compare unit
        ST_SCAN: begin
          rd_vld_q <= (j_q < i_q);
          rd_idx_q <= j_q;
          if (j_q < i_q) begin
            j_q <= j_q + 1'b1;
          end else if (!rd_vld_q) begin
            state_q <= ST_MERGE1;
          end
        end
        ST_MERGE1: begin
          has_parent_q[mstat.p1] <= 1'b1;
          has_parent_q[mstat.p2] <= 1'b1;
          state_q                <= ST_MERGE2;
        end
        ST_MERGE2: begin
          if (i_q == IDX_W'(ROOT)) begin
            leaf_q  <= '0;
            state_q <= ST_CODE_START;
          end else begin
            i_q     <= i_q + 1'b1;
            j_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        // walk each leaf up to the root
        ST_CODE_START: begin
          c_q     <= IDX_W'(leaf_q);
          word_q  <= '0;
          len_q   <= '0;
          state_q <= ST_CODE_CHK;
        end
        ST_CODE_CHK: begin
          if (walk_end) begin
            if (leaf_q == LEAF_W'(LEAVES - 1)) begin
              built_q       <= 1'b1;
              decode_node_q <= IDX_W'(ROOT);
              out_valid_q   <= 1'b1;
              kind_q        <= RK_BUILD;
              osym_q        <= '0;
              oword_q       <= '0;
              olen_q        <= '0;
              state_q       <= ST_IDLE;
            end else begin
              leaf_q  <= leaf_q + 1'b1;
              state_q <= ST_CODE_START;
            end
          end else begin
            p_q     <= par_rd_q;
            state_q <= ST_CODE_STEP;
          end
        end
        ST_CODE_STEP: begin
          word_q  <= word_q | (CODE_W'(step_bit) << len_q);
          len_q   <= len_q + 1'b1;
          c_q     <= p_q;
          state_q <= ST_CODE_CHK;
        end
        ST_ENC: begin
          out_valid_q <= 1'b1;
          kind_q      <= RK_ENCODE;
          osym_q      <= sym_q;
          if (sym_q < LEAF_W'(LEAVES)) begin
            oword_q <= code_rd_q[CODE_W-1:0];
            olen_q  <= code_rd_q[LEN_W+CODE_W-1:CODE_W];
          end else begin
            oword_q <= '0;
            olen_q  <= '0;
          end
          state_q <= ST_IDLE;
        end
        ST_DEC: begin
          if (dec_next < IDX_W'(LEAVES)) begin
            decode_node_q <= IDX_W'(ROOT);
            out_valid_q   <= 1'b1;
            kind_q        <= RK_DECODE;
            osym_q        <= dec_next[LEAF_W-1:0];
            oword_q       <= '0;
            olen_q        <= '0;
          end else begin
            decode_node_q <= dec_next;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.out_symbol  = osym_q;
  assign out_o.code_word   = oword_q;
  assign out_o.code_length = olen_q;

  // checks
  `HCU_ASSERT_NEXT(a_busy_after_accept, accept, !in_i.ready, "ready held after transaction")
  `HCU_ASSERT_NOW(a_dec_at_root, out_valid_q && (kind_q == RK_DECODE), decode_node_q == IDX_W'(ROOT), "decode position not at root after symbol")
  `HCU_ASSERT_NOW(a_min_distinct, (state_q == ST_MERGE1), mstat.have2 && (mstat.p1 != mstat.p2), "merge children not two distinct nodes")

endmodule

`default_nettype wire

[tb/huff_tb_if.sv]
// Testbench note: the channel interfaces come from hdl/huff_if.sv.
// This file holds the shared test item types; depends on huff_pkg.
`default_nettype none

package huff_tb_pkg;
  import huff_pkg::*;

  // one input transaction
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [LEAF_W-1:0] symbol;
    logic [LOAD_W-1:0] weight;
    logic              code_bit;
  } op_item_t;

  // one result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEAF_W-1:0] sym;
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } res_item_t;
endpackage

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for huffman_codec_unit: loads weights, builds trees,
// encodes symbols and decodes code streams against an in-bench codec model.
// Depends on huff_pkg, huff_if.sv and huff_tb_pkg.
`default_nettype none

module testbench;
  import huff_pkg::*;
  import huff_tb_pkg::*;

  localparam int MAX_CYCLES = 4000000;

  logic clk_i;
  logic rst_ni;

  huff_in_if  in_ch ();
  huff_out_if out_ch ();

  huffman_codec_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // codec model state
  logic [WGT_W-1:0]  mdl_wgt [NODES];
  logic [IDX_W-1:0]  mdl_par [NODES];
  logic [IDX_W-1:0]  mdl_lft [NODES];
  logic [IDX_W-1:0]  mdl_rgt [NODES];
  logic [CODE_W-1:0] mdl_code [LEAVES];
  logic [LEN_W-1:0]  mdl_clen [LEAVES];
  logic [IDX_W-1:0]  mdl_walk;

  op_item_t  op_queue [$];
  res_item_t expected_results [$];
  int        mismatches;
  int        cycle_count;
  bit        stim_done;
  bit        no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Tree build: merge two lightest parentless nodes, then walk each leaf up.
  task automatic build_tree_model();
    int i, j, p1, p2, c, p;
    bit h1, h2;
    logic [WGT_W-1:0] l1, l2;
    logic [CODE_W-1:0] w;
    int n;
    for (i = 0; i < NODES; i++) begin
      mdl_par[i] = '0; mdl_lft[i] = '0; mdl_rgt[i] = '0;
      if (i >= LEAVES) mdl_wgt[i] = '0;
    end
    for (i = LEAVES; i < NODES; i++) begin
      h1 = 0; h2 = 0; l1 = 0; l2 = 0; p1 = 0; p2 = 0;
      for (j = 0; j < i; j++) begin
        if (mdl_par[j] != 0) continue;
        if (!h1 || mdl_wgt[j] < l1) begin
          l2 = l1; p2 = p1; h2 = h1;
          l1 = mdl_wgt[j]; p1 = j; h1 = 1;
        end else if (!h2 || mdl_wgt[j] < l2) begin
          l2 = mdl_wgt[j]; p2 = j; h2 = 1;
        end
      end
      mdl_par[p1] = IDX_W'(i); mdl_par[p2] = IDX_W'(i);
      mdl_lft[i] = IDX_W'(p1); mdl_rgt[i] = IDX_W'(p2);
      mdl_wgt[i] = mdl_wgt[p1] + mdl_wgt[p2];
    end
    mdl_par[ROOT] = '0;
    for (i = 0; i < LEAVES; i++) begin
      w = '0; n = 0; c = i; p = mdl_par[i];
      while (p != 0 && p < NODES && n < LEAVES - 1) begin
        if (mdl_lft[p] != c) w[n] = 1'b1;
        n++; c = p; p = mdl_par[p];
      end
      mdl_code[i] = w; mdl_clen[i] = LEN_W'(n);
    end
    mdl_walk = IDX_W'(ROOT);
  endtask

  // Apply one accepted transaction to the model; queue any result it causes.
  task automatic predict_codec(input op_item_t it);
    res_item_t r;
    int cur, nxt;
    r = '0;
    case (it.opcode)
      OP_LOAD: if (it.symbol < LEAVES) mdl_wgt[it.symbol] = WGT_W'(it.weight);
      OP_BUILD: begin
        build_tree_model();
        r.kind = RK_BUILD;
        expected_results.push_back(r);
      end
      OP_ENCODE: begin
        r.kind = RK_ENCODE; r.sym = it.symbol;
        if (it.symbol < LEAVES) begin
          r.word = mdl_code[it.symbol]; r.len = mdl_clen[it.symbol];
        end
        expected_results.push_back(r);
      end
      default: begin
        cur = (mdl_walk < NODES) ? mdl_walk : ROOT;
        nxt = it.code_bit ? mdl_rgt[cur] : mdl_lft[cur];
        if (nxt >= NODES) nxt = ROOT;
        if (nxt < LEAVES) begin
          mdl_walk = IDX_W'(ROOT);
          r.kind = RK_DECODE; r.sym = LEAF_W'(nxt);
          expected_results.push_back(r);
        end else begin
          mdl_walk = IDX_W'(nxt);
        end
      end
    endcase
  endtask

  // stimulus helpers: they only fill the queue
  function automatic op_item_t mk(logic [OP_W-1:0] op, int sym, int wgt, bit b);
    op_item_t t;
    t.opcode = op; t.symbol = LEAF_W'(sym); t.weight = LOAD_W'(wgt); t.code_bit = b;
    return t;
  endfunction

  // random weight profile, sometimes flat or extreme
  task automatic queue_weights(input int style);
    int s;
    for (s = 0; s < LEAVES; s++) begin
      case (style)
        0: op_queue.push_back(mk(OP_LOAD, s, $urandom_range(0, 65535), $urandom));
        1: op_queue.push_back(mk(OP_LOAD, s, 16'hFFFF, $urandom));
        2: op_queue.push_back(mk(OP_LOAD, s, 0, $urandom));
        default: op_queue.push_back(mk(OP_LOAD, s, $urandom_range(0, 15), $urandom));
      endcase
    end
  endtask

  // Code stream for random symbols; needs a model of the codes, so it is
  // built here from the same weights the block will see.
  logic [WGT_W-1:0] plan_wgt [LEAVES];

  task automatic queue_stream(input int syms);
    int k, b, s;
    logic [CODE_W-1:0] w;
    logic [LEN_W-1:0] n;
    // rebuild codes with the planned weights in a scratch copy
    logic [WGT_W-1:0] keep [LEAVES];
    for (s = 0; s < LEAVES; s++) begin
      keep[s] = mdl_wgt[s]; mdl_wgt[s] = plan_wgt[s];
    end
    build_tree_model();
    for (k = 0; k < syms; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        op_queue.push_back(mk(OP_ENCODE, $urandom_range(0, 31), $urandom, $urandom));
        continue;
      end
      s = $urandom_range(0, LEAVES - 1);
      w = mdl_code[s]; n = mdl_clen[s];
      for (b = n - 1; b >= 0; b--)
        op_queue.push_back(mk(OP_DECODE, $urandom, $urandom, w[b]));
      if ($urandom_range(0, 3) == 0)
        op_queue.push_back(mk(OP_ENCODE, s, $urandom, $urandom));
    end
    for (s = 0; s < LEAVES; s++) mdl_wgt[s] = keep[s];
    for (s = 0; s < NODES; s++) begin
      mdl_par[s] = '0; mdl_lft[s] = '0; mdl_rgt[s] = '0;
      if (s >= LEAVES) mdl_wgt[s] = '0;
    end
    mdl_walk = IDX_W'(ROOT);
  endtask

  // Stimulus generation; the model is reset again afterwards for checking.
  initial begin
    int g, s, style;
    for (s = 0; s < NODES; s++) begin
      mdl_wgt[s] = '0; mdl_par[s] = '0; mdl_lft[s] = '0; mdl_rgt[s] = '0;
    end
    for (s = 0; s < LEAVES; s++) begin
      mdl_code[s] = '0; mdl_clen[s] = '0; plan_wgt[s] = '0;
    end
    mdl_walk = IDX_W'(ROOT);
    // directed: decode before build, out-of-range load and encode
    op_queue.push_back(mk(OP_DECODE, 0, 0, 1'b0));
    op_queue.push_back(mk(OP_DECODE, 31, 16'hFFFF, 1'b1));
    op_queue.push_back(mk(OP_LOAD, 27, 16'hFFFF, 1'b0));
    op_queue.push_back(mk(OP_LOAD, 31, 16'hAAAA, 1'b1));
    op_queue.push_back(mk(OP_ENCODE, 31, 16'h5555, 1'b0));
    op_queue.push_back(mk(OP_ENCODE, 27, 0, 1'b1));
    // all-equal weights (tie rule), then build and encode extremes
    op_queue.push_back(mk(OP_BUILD, 0, 0, 0));
    op_queue.push_back(mk(OP_ENCODE, 0, 0, 0));
    op_queue.push_back(mk(OP_ENCODE, 26, 16'hFFFF, 1));
    for (s = 0; s < 8; s++) op_queue.push_back(mk(OP_DECODE, s, 0, s[0]));
    // random phases: weights, build, stream
    for (g = 0; g < 24; g++) begin
      style = (g < 2) ? g + 1 : (g % 5 == 4) ? 3 : 0;
      queue_weights(style);
      for (s = 0; s < LEAVES; s++) plan_wgt[s] = op_queue[op_queue.size()-LEAVES+s].weight;
      op_queue.push_back(mk(OP_BUILD, $urandom, $urandom, $urandom));
      queue_stream(8);
      // some noise bits, then a rebuild to realign the walk
      if (g % 3 == 0) begin
        for (s = 0; s < 4; s++)
          op_queue.push_back(mk(OP_DECODE, $urandom, $urandom, $urandom));
        op_queue.push_back(mk(OP_BUILD, 0, 0, 0));
      end
    end
    // restore model to reset state for checking
    for (s = 0; s < NODES; s++) begin
      mdl_wgt[s] = '0; mdl_par[s] = '0; mdl_lft[s] = '0; mdl_rgt[s] = '0;
    end
    mdl_walk = IDX_W'(ROOT);
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Driver: presents the queue head, idles at random, changes at falling edge.
  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.symbol = '0;
    in_ch.weight = '0; in_ch.code_bit = 1'b0;
    out_ch.ready = 1'b0;
    stim_done = 0; no_idle = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      no_idle <= (cycle_count % 6000) < 1500;
      // hand off only after acceptance was seen at the rising edge
      if (!in_ch.valid || in_ch.ready) begin
        if (op_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10)) begin
          in_ch.valid    <= 1'b1;
          in_ch.opcode   <= op_queue[0].opcode;
          in_ch.symbol   <= op_queue[0].symbol;
          in_ch.weight   <= op_queue[0].weight;
          in_ch.code_bit <= op_queue[0].code_bit;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: input acceptance feeds the model, output acceptance is checked.
  always @(posedge clk_i) begin
    op_item_t  took;
    res_item_t got, want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        took.opcode = in_ch.opcode; took.symbol = in_ch.symbol;
        took.weight = in_ch.weight; took.code_bit = in_ch.code_bit;
        void'(op_queue.pop_front());
        predict_codec(took);
        if (op_queue.size() == 0) stim_done <= 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.result_kind; got.sym = out_ch.out_symbol;
        got.word = out_ch.code_word; got.len = out_ch.code_length;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d sym %0d word %h len %0d",
                     got.kind, got.sym, got.word, got.len);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind %0d sym %0d word %h len %0d, got %0d %0d %h %0d",
                       want.kind, want.sym, want.word, want.len,
                       got.kind, got.sym, got.word, got.len);
          end
        end
      end
    end
  end

  // End of run and watchdog.
  initial begin
    mismatches = 0; cycle_count = 0;
    fork
      begin
        wait (stim_done && expected_results.size() == 0);
        repeat (50) @(posedge clk_i);
        if (mismatches == 0 && expected_results.size() == 0) begin
          $display("ALL CHECKS PASSED");
        end else begin
          $display("CHECKS FAILED");
        end
        $finish;
      end
      begin
        while (cycle_count < MAX_CYCLES) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
      end
    join
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/huff_pkg.sv
hdl/huff_if.sv
hdl/huff_min_track.sv
hdl/huffman_codec_unit.sv
tb/huff_tb_if.sv
tb/testbench.sv
